### sv/receive_ring_page_walker_macros.svh
// Assertion macros for the receive ring page walker.
// Used by the top level; no other dependencies.
`ifndef RECEIVE_RING_PAGE_WALKER_MACROS_SVH
`define RECEIVE_RING_PAGE_WALKER_MACROS_SVH
`ifndef SYNTHESIS
`define RRPW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrpw: assertion failed");
`define RRPW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrpw: assertion failed");
`else
`define RRPW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RRPW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/rrpw_pkg.sv
// Shared types and constants for the receive ring page walker.
// No dependencies.
package rrpw_pkg;

    localparam logic [7:0] RESET_START_PAGE = 8'd70;
    localparam logic [7:0] RESET_STOP_PAGE  = 8'd128;

    localparam int INTACT_BIT  = 0;
    localparam int OVERRUN_BIT = 3;

    // configuration register indexes
    localparam logic [0:0] CFG_RING_START = 1'b0;
    localparam logic [0:0] CFG_RING_STOP  = 1'b1;

    typedef enum logic [2:0] {
        OUT_EMPTY     = 3'd0,
        OUT_DELIVERED = 3'd1,
        OUT_BAD_LEN   = 3'd2,
        OUT_BAD_NEXT  = 3'd3,
        OUT_OVERRUN   = 3'd4,
        OUT_SKIPPED   = 3'd5
    } t_outcome;

    typedef struct packed {
        logic        chip_stopped;
        logic [15:0] max_length;
        logic [15:0] byte_count;
        logic [7:0]  next_page;
        logic [7:0]  rx_status;
        logic [7:0]  curr_page;
    } t_hdr;

    typedef struct packed {
        logic        reset_needed;
        logic [7:0]  new_boundary;
        logic [15:0] second_count;
        logic [15:0] second_address;
        logic [15:0] first_count;
        logic [15:0] first_address;
        logic [15:0] frame_length;
        t_outcome    outcome;
    } t_res;

endpackage

### sv/rrpw_in_stage.sv
// Input register stage of the receive ring page walker.
// Depends on rrpw_pkg.
module rrpw_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rrpw_pkg::t_hdr i_hdr,
    output logic          o_ready,
    input  logic          i_take,
    output logic          o_valid,
    output rrpw_pkg::t_hdr o_hdr
);

    logic           r_valid;
    rrpw_pkg::t_hdr r_hdr;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_hdr   = r_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hdr <= i_hdr;
        end
    end

endmodule

### sv/rrpw_eval.sv
// Header evaluation: ring read page, checks, copy segments, new boundary.
// Depends on rrpw_pkg; purely combinational.
module rrpw_eval #(
    parameter int PAGE_BYTES   = 256,
    parameter int MIN_FRAME    = 60,
    parameter int HEADER_BYTES = 4
) (
    input  rrpw_pkg::t_hdr i_hdr,
    input  logic [7:0]     i_boundary,
    input  logic [7:0]     i_start,
    input  logic [7:0]     i_stop,
    output rrpw_pkg::t_res o_res
);

    localparam int PB_W   = $clog2(PAGE_BYTES) + 1;
    localparam int PROD_W = 8 + PB_W;
    localparam int CMP_W  = (PROD_W > 17) ? PROD_W : 17;

    logic [7:0]        page_inc, page, nxt, span;
    logic              empty, short_cnt, bad_len, bad_link, fail, wrap, stop_above;
    logic [15:0]       len, len_m1, split, c1, c2, a1, a2;
    logic [CMP_W-1:0]  span_bytes, split_full;
    rrpw_pkg::t_outcome outcome;

    always_comb begin
        page_inc = i_boundary + 8'd1;
        page     = (page_inc == i_stop) ? i_start : page_inc;
        empty    = (i_hdr.curr_page == page);

        short_cnt = (i_hdr.byte_count < 16'(HEADER_BYTES));
        len       = short_cnt ? 16'd0 : (i_hdr.byte_count - 16'(HEADER_BYTES));
        len_m1    = len - 16'd1;
        bad_len   = short_cnt || (len < 16'(MIN_FRAME)) || (len > i_hdr.max_length);
        bad_link  = (i_hdr.next_page < i_start) || (i_hdr.next_page >= i_stop);

        // frame wraps when its last page reaches the stop page:
        // (len-1)/PAGE_BYTES >= stop-page, written as a product compare
        stop_above = (i_stop > page);
        span       = i_stop - page;
        span_bytes = CMP_W'(span) * CMP_W'(PAGE_BYTES);
        wrap       = !stop_above || (CMP_W'(len_m1) >= span_bytes);
        split_full = span_bytes - CMP_W'(HEADER_BYTES);
        if (!stop_above) begin
            split = 16'd0;
        end else if (split_full > CMP_W'(len)) begin
            split = len;
        end else begin
            split = split_full[15:0];
        end
        c1 = wrap ? split : len;
        c2 = wrap ? (len - split) : 16'd0;
        a1 = 16'(page) * 16'(PAGE_BYTES) + 16'(HEADER_BYTES);
        a2 = 16'(i_start) * 16'(PAGE_BYTES);

        priority if (bad_len) begin
            outcome = rrpw_pkg::OUT_BAD_LEN;
        end else if (bad_link) begin
            outcome = rrpw_pkg::OUT_BAD_NEXT;
        end else if (i_hdr.rx_status[rrpw_pkg::OVERRUN_BIT]) begin
            outcome = rrpw_pkg::OUT_OVERRUN;
        end else if (i_hdr.rx_status[rrpw_pkg::INTACT_BIT]) begin
            outcome = rrpw_pkg::OUT_DELIVERED;
        end else begin
            outcome = rrpw_pkg::OUT_SKIPPED;
        end

        // any failed check drops the ring back to the chip's write page
        fail = bad_len || bad_link || i_hdr.rx_status[rrpw_pkg::OVERRUN_BIT];
        nxt  = fail ? i_hdr.curr_page : i_hdr.next_page;

        o_res = '0;
        if (empty) begin
            o_res.outcome      = rrpw_pkg::OUT_EMPTY;
            o_res.new_boundary = i_boundary;
            o_res.reset_needed = i_hdr.chip_stopped;
        end else begin
            o_res.outcome      = outcome;
            o_res.frame_length = len;
            o_res.new_boundary = (nxt == i_start) ? (i_stop - 8'd1) : (nxt - 8'd1);
            if (outcome == rrpw_pkg::OUT_DELIVERED) begin
                o_res.first_address  = a1;
                o_res.first_count    = c1;
                o_res.second_address = a2;
                o_res.second_count   = c2;
            end
        end
    end

endmodule

### sv/receive_ring_page_walker.sv
// Receive ring page walker: one result beat per receive header beat.
// The header is held in the input register, then the result in the result register; one beat
// per cycle sustained while m_tready holds, set by the boundary register loop.
// Synchronous active-low reset empties both stages, sets ring start/stop to
// 70/128 and the boundary page to 70. Boundary is not touched by config writes.
`include "receive_ring_page_walker_macros.svh"
module receive_ring_page_walker #(
    parameter int PAGE_BYTES   = 256,
    parameter int MIN_FRAME    = 60,
    parameter int HEADER_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // header stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // curr_page[7:0], rx_status[15:8], next_page[23:16],
    // byte_count[39:24], max_length[55:40]
    input  logic [55:0] s_tdata,
    // chip_stopped[0]
    input  logic [0:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_length[15:0], first_address[31:16], first_count[47:32],
    // second_address[63:48], second_count[79:64], new_boundary[87:80]
    output logic [87:0] m_tdata,
    // outcome[2:0], reset_needed[3]
    output logic [3:0]  m_tuser
);

    logic [7:0]     r_start, r_stop, r_boundary;
    logic           r_out_valid;
    rrpw_pkg::t_res r_out;

    rrpw_pkg::t_hdr in_hdr, s1_hdr;
    rrpw_pkg::t_res res;
    logic           s1_valid, s1_take;

    assign in_hdr.curr_page    = s_tdata[7:0];
    assign in_hdr.rx_status    = s_tdata[15:8];
    assign in_hdr.next_page    = s_tdata[23:16];
    assign in_hdr.byte_count   = s_tdata[39:24];
    assign in_hdr.max_length   = s_tdata[55:40];
    assign in_hdr.chip_stopped = s_tuser[0];

    assign s1_take = s1_valid && (!r_out_valid || m_tready);

    rrpw_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_hdr   (in_hdr),
        .o_ready (s_tready),
        .i_take  (s1_take),
        .o_valid (s1_valid),
        .o_hdr   (s1_hdr)
    );

    rrpw_eval #(
        .PAGE_BYTES   (PAGE_BYTES),
        .MIN_FRAME    (MIN_FRAME),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_eval (
        .i_hdr      (s1_hdr),
        .i_boundary (r_boundary),
        .i_start    (r_start),
        .i_stop     (r_stop),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= rrpw_pkg::RESET_START_PAGE;
            r_stop  <= rrpw_pkg::RESET_STOP_PAGE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rrpw_pkg::CFG_RING_START: r_start <= i_cfg_data;
                rrpw_pkg::CFG_RING_STOP:  r_stop  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boundary  <= rrpw_pkg::RESET_START_PAGE;
            r_out_valid <= 1'b0;
        end else if (s1_take) begin
            r_boundary  <= res.new_boundary;
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out.new_boundary, r_out.second_count, r_out.second_address,
                       r_out.first_count, r_out.first_address, r_out.frame_length};
    assign m_tuser  = {r_out.reset_needed, r_out.outcome};

    // delivered segments add up to the frame
    `RRPW_ASSERT_IMP(a_seg_sum, i_clk, i_rst_n, r_out_valid && (r_out.outcome == rrpw_pkg::OUT_DELIVERED), (r_out.first_count + r_out.second_count) == r_out.frame_length)
    // no copy segments unless delivered
    `RRPW_ASSERT_IMP(a_no_seg, i_clk, i_rst_n, r_out_valid && (r_out.outcome != rrpw_pkg::OUT_DELIVERED), (r_out.first_count == 16'd0) && (r_out.second_count == 16'd0))
    // reset request only on an empty ring
    `RRPW_ASSERT_IMP(a_rst_empty, i_clk, i_rst_n, r_out_valid && r_out.reset_needed, r_out.outcome == rrpw_pkg::OUT_EMPTY)
    // a held header stays in the input stage while the result is stalled
    `RRPW_ASSERT_NXT(a_s1_hold, i_clk, i_rst_n, s1_valid && r_out_valid && !m_tready, s1_valid && (r_boundary == $past(r_boundary)))

endmodule

### tb/tb_receive_ring_page_walker.sv
// Self-checking testbench for receive_ring_page_walker: directed header cases, then random
// traffic over several ring settings, with a per-header predictor of the boundary walk.
// Depends on rrpw_pkg and the receive_ring_page_walker RTL.
module tb_receive_ring_page_walker;

    localparam int PAGE_BYTES   = 256;
    localparam int MIN_FRAME    = 60;
    localparam int HEADER_BYTES = 4;

    typedef struct packed {
        rrpw_pkg::t_outcome outcome;
        logic [15:0] frame_length;
        logic [15:0] first_address;
        logic [15:0] first_count;
        logic [15:0] second_address;
        logic [15:0] second_count;
        logic [7:0]  new_boundary;
        logic        reset_needed;
    } t_ring_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // curr_page, rx_status, next_page, byte_count, max_length from bit 0 up
    logic [55:0] s_tdata = '0;
    // chip_stopped
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // frame_length, first_address, first_count, second_address, second_count,
    // new_boundary from bit 0 up
    logic [87:0] m_tdata;
    // outcome, reset_needed from bit 0 up
    logic [3:0]  m_tuser;

    // predictor state
    logic [7:0] cfg_start_page = rrpw_pkg::RESET_START_PAGE;
    logic [7:0] cfg_stop_page  = rrpw_pkg::RESET_STOP_PAGE;
    logic [7:0] boundary_pg    = rrpw_pkg::RESET_START_PAGE;

    t_ring_result pending_results[$];
    int err_count = 0;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_cycle = 0;

    receive_ring_page_walker uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #500000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // page the block reads next: boundary + 1, wrapping to ring start at the stop page
    function automatic logic [7:0] read_page();
        logic [7:0] p;
        p = boundary_pg + 8'd1;
        if (p == cfg_stop_page) p = cfg_start_page;
        return p;
    endfunction

    // a page inside the ring that is not the read page
    function automatic logic [7:0] other_page();
        return (read_page() == cfg_start_page) ? cfg_stop_page - 8'd1 : cfg_start_page;
    endfunction

    function automatic t_ring_result walk_ring_header(
        input logic [7:0]  curr,
        input logic [7:0]  status,
        input logic [7:0]  link,
        input logic [15:0] count,
        input logic [15:0] maxlen,
        input logic        stopped
    );
        t_ring_result r;
        logic [7:0]  page;
        logic [7:0]  nxt;
        int unsigned len;
        int unsigned last_pg;
        int unsigned split;
        r = '0;
        page = read_page();
        if (curr == page) begin
            r.outcome = rrpw_pkg::OUT_EMPTY;
            r.new_boundary = boundary_pg;
            r.reset_needed = stopped;
            return r;
        end
        len = (count >= HEADER_BYTES) ? count - HEADER_BYTES : 0;
        nxt = link;
        if (count < HEADER_BYTES || len < MIN_FRAME || len > maxlen) begin
            r.outcome = rrpw_pkg::OUT_BAD_LEN;
            nxt = curr;
        end else if (link < cfg_start_page || link >= cfg_stop_page) begin
            r.outcome = rrpw_pkg::OUT_BAD_NEXT;
            nxt = curr;
        end else if (status[rrpw_pkg::OVERRUN_BIT]) begin
            r.outcome = rrpw_pkg::OUT_OVERRUN;
            nxt = curr;
        end else if (status[rrpw_pkg::INTACT_BIT]) begin
            r.outcome = rrpw_pkg::OUT_DELIVERED;
            last_pg = page + (len - 1) / PAGE_BYTES;
            r.first_address = 16'(page * PAGE_BYTES + HEADER_BYTES);
            r.second_address = 16'(cfg_start_page * PAGE_BYTES);
            if (last_pg >= cfg_stop_page) begin
                split = 0;
                if (cfg_stop_page > page)
                    split = (cfg_stop_page - page) * PAGE_BYTES - HEADER_BYTES;
                if (split > len) split = len;
                r.first_count = 16'(split);
                r.second_count = 16'(len - split);
            end else begin
                r.first_count = 16'(len);
            end
        end else begin
            r.outcome = rrpw_pkg::OUT_SKIPPED;
        end
        boundary_pg = (nxt == cfg_start_page) ? cfg_stop_page - 8'd1 : nxt - 8'd1;
        r.frame_length = 16'(len);
        r.new_boundary = boundary_pg;
        return r;
    endfunction

    task automatic send_header(
        input logic [7:0]  curr,
        input logic [7:0]  status,
        input logic [7:0]  link,
        input logic [15:0] count,
        input logic [15:0] maxlen,
        input logic        stopped
    );
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 80);
            end else begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(1, 8);
                s_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_tdata = {maxlen, count, link, status, curr};
        s_tuser = stopped;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(walk_ring_header(curr, status, link, count, maxlen, stopped));
    endtask

    // stop sending and let every pending beat drain out of the pipeline
    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_ring_reg(input logic [0:0] idx, input logic [7:0] value);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        if (idx == rrpw_pkg::CFG_RING_START) cfg_start_page = value;
        else cfg_stop_page = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // receiver: ready pattern switches between several modes
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 150);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 9) != 0);
            default: m_tready <= (rx_cycle % 3 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_ring_result exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no header pending");
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("outcome", 32'(exp_r.outcome), 32'(m_tuser[2:0]));
                check_field("reset_needed", 32'(exp_r.reset_needed), 32'(m_tuser[3]));
                check_field("frame_length", 32'(exp_r.frame_length), 32'(m_tdata[15:0]));
                check_field("first_address", 32'(exp_r.first_address), 32'(m_tdata[31:16]));
                check_field("first_count", 32'(exp_r.first_count), 32'(m_tdata[47:32]));
                check_field("second_address", 32'(exp_r.second_address),
                            32'(m_tdata[63:48]));
                check_field("second_count", 32'(exp_r.second_count), 32'(m_tdata[79:64]));
                check_field("new_boundary", 32'(exp_r.new_boundary), 32'(m_tdata[87:80]));
            end
        end
    end

    task automatic test_empty_ring();
        send_header(read_page(), 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1);
        send_header(read_page(), 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    endtask

    task automatic test_header_checks();
        // short byte counts, frame below minimum, frame above max_length
        send_header(other_page(), 8'h01, 8'd100, 16'd0, 16'd1518, 1'b0);
        send_header(other_page(), 8'h01, 8'd100, 16'd3, 16'd1518, 1'b1);
        send_header(other_page(), 8'h01, 8'd100, 16'd63, 16'd1518, 1'b0);
        send_header(other_page(), 8'h01, 8'd100, 16'd64, 16'd0, 1'b0);
        // link outside the ring
        send_header(other_page(), 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_header(other_page(), 8'h01, cfg_start_page - 8'd1, 16'd200, 16'd1518, 1'b0);
        send_header(other_page(), 8'h01, cfg_stop_page, 16'd200, 16'd1518, 1'b0);
        // overrun alone and over intact, neither bit set, a frame of exactly max_length
        send_header(other_page(), 8'h08, 8'd100, 16'd200, 16'd1518, 1'b0);
        send_header(other_page(), 8'hFF, 8'd100, 16'd200, 16'd1518, 1'b0);
        send_header(other_page(), 8'hF6, 8'd90, 16'd200, 16'd1518, 1'b0);
        send_header(other_page(), 8'h01, 8'd100, 16'd64, 16'd60, 1'b0);
        // park the read page two pages before stop, then deliver across the wrap
        send_header(cfg_stop_page - 8'd2, 8'h01, 8'd100, 16'd0, 16'd1518, 1'b0);
        send_header(cfg_start_page, 8'h01, cfg_start_page + 8'd3, 16'd1004, 16'd1518, 1'b0);
    endtask

    task automatic test_ring_edges();
        // read page beyond the stop page: whole frame goes to the wrapped segment
        send_header(8'd200, 8'h00, 8'd0, 16'd0, 16'd1518, 1'b0);
        send_header(8'd90, 8'h01, 8'd80, 16'd104, 16'd1518, 1'b0);
        // boundary lands on 255 and the read page wraps to 0
        write_ring_reg(rrpw_pkg::CFG_RING_START, 8'd10);
        write_ring_reg(rrpw_pkg::CFG_RING_STOP, 8'd200);
        send_header(8'd0, 8'h00, 8'd0, 16'd0, 16'd1518, 1'b0);
        send_header(8'd0, 8'h00, 8'd0, 16'd0, 16'd1518, 1'b1);
        send_header(8'd5, 8'h00, 8'd20, 16'd100, 16'd1518, 1'b0);
        // stop page zero: stop - 1 wraps to 255
        write_ring_reg(rrpw_pkg::CFG_RING_START, 8'd0);
        write_ring_reg(rrpw_pkg::CFG_RING_STOP, 8'd0);
        send_header(8'd0, 8'h01, 8'd5, 16'd0, 16'd1518, 1'b0);
        send_header(8'd9, 8'h01, 8'd5, 16'd200, 16'd1518, 1'b0);
    endtask

    task automatic run_traffic_phase(input logic [7:0] start_pg, input logic [7:0] stop_pg,
                                     input int n_items);
        logic [7:0]  curr;
        logic [7:0]  status;
        logic [7:0]  link;
        logic [15:0] maxlen;
        int unsigned len;
        int unsigned span;
        int          roll;
        bit          ring_ok;
        write_ring_reg(rrpw_pkg::CFG_RING_START, start_pg);
        write_ring_reg(rrpw_pkg::CFG_RING_STOP, stop_pg);
        ring_ok = (start_pg < stop_pg);
        span = ring_ok ? (stop_pg - start_pg) * PAGE_BYTES : PAGE_BYTES;
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                send_header(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                            16'($urandom), 1'($urandom));
            end else begin
                if (roll < 25) curr = read_page();
                else if (ring_ok) curr = 8'($urandom_range(start_pg, stop_pg - 8'd1));
                else curr = 8'($urandom);
                if (ring_ok && $urandom_range(0, 9) != 0)
                    link = 8'($urandom_range(start_pg, stop_pg - 8'd1));
                else
                    link = 8'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 70) maxlen = 16'd1518;
                else if (roll < 90) maxlen = 16'($urandom);
                else maxlen = 16'hFFFF;
                roll = $urandom_range(0, 99);
                if (roll < 80) len = $urandom_range(60, 1514);
                else if (roll < 95) len = $urandom_range(60, (span > 60) ? span : 60);
                else len = $urandom_range(0, 80);
                status = 8'($urandom);
                if ($urandom_range(0, 99) < 85) begin
                    status[rrpw_pkg::INTACT_BIT] = 1'b1;
                    status[rrpw_pkg::OVERRUN_BIT] = 1'b0;
                end
                send_header(curr, status, link, 16'(len + HEADER_BYTES), maxlen,
                            1'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0] s;
        run_traffic_phase(8'd0, 8'd255, 90);
        run_traffic_phase(rrpw_pkg::RESET_START_PAGE, rrpw_pkg::RESET_STOP_PAGE, 80);
        run_traffic_phase(8'd1, 8'd2, 35);
        run_traffic_phase(8'd255, 8'd1, 25);
        repeat (3) begin
            s = 8'($urandom_range(0, 200));
            run_traffic_phase(s, 8'($urandom_range(32'(s) + 1, 255)), 55);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_ring();
        test_header_checks();
        test_ring_edges();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### receive_ring_page_walker.f
+incdir+sv
sv/rrpw_pkg.sv
sv/rrpw_in_stage.sv
sv/rrpw_eval.sv
sv/receive_ring_page_walker.sv
tb/tb_receive_ring_page_walker.sv
